// File: rtl/core/fft_pkg.sv
`default_nettype none
package fft_pkg;
  localparam int TABLE_ENTRIES = 32;
  localparam int ADDR_BITS     = 16;
  localparam int KEY_BITS      = 16;
  localparam int LEN_BITS      = 17;
  localparam int REQ_BITS      = 3;
  localparam int STATUS_BITS   = 3;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int END_W         = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 2;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_STORE  = 3'd0,
    REQ_LOOKUP = 3'd1,
    REQ_ERASE  = 3'd2,
    REQ_RENAME = 3'd3,
    REQ_GAP    = 3'd4,
    REQ_PACK   = 3'd5,
    REQ_RSVD6  = 3'd6,
    REQ_RSVD7  = 3'd7
  } req_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  len;
  } entry_t;
endpackage
`default_nettype wire

// File: rtl/core/fft_if.sv
`default_nettype none
interface fft_req_if import fft_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REQ_BITS-1:0]  req_type;
  logic [KEY_BITS-1:0]  file_key;
  logic [KEY_BITS-1:0]  new_key;
  logic [LEN_BITS-1:0]  file_size;
  modport source (output valid, req_type, file_key, new_key, file_size, input ready);
  modport sink (input valid, req_type, file_key, new_key, file_size, output ready);
endinterface

interface fft_rsp_if import fft_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [ADDR_BITS-1:0]   start_addr;
  logic [LEN_BITS-1:0]    length;
  modport source (output valid, status, start_addr, length, input ready);
  modport sink (input valid, status, start_addr, length, output ready);
endinterface

interface fft_cfg_if import fft_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEN_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fft_cell.sv
`default_nettype none
module fft_cell import fft_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   shift_i,
  input  wire entry_t entry_i,
  output entry_t      entry_o
);
  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;
endmodule
`default_nettype wire

// File: rtl/core/first_fit_extent_table.sv
// First-fit extent table.
// req channel: one request per transfer (store, lookup, erase, rename,
//   largest free gap, pack). rsp channel: exactly one response per request,
//   in request order. cfg channel: memory size in bytes, always ready; write
//   it only while no request is in flight.
// The extents live in a ring of TABLE_ENTRIES cells that rotates by one entry
// per cycle while a request scans or modifies it; the controller reads the head
// cell and drives the tail cell. Every request takes one scan pass over the
// ring, then a decide state and a response state; good store, rename and erase
// requests add a modify pass over the ring before the response, and a good
// erase's modify pass rotates one entry further than the others.
// One request is processed at a time; a new request is accepted only after
// the previous one has left its response state.
// The response sits in an output register, so a stalled receiver only blocks
// the finish of the next request. Reset empties the table and sets the memory
// size to 65536 bytes; no clearing pass is needed.
`default_nettype none
module first_fit_extent_table import fft_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fft_cfg_if.sink   cfg,
  fft_req_if.sink   req,
  fft_rsp_if.source rsp
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_MOD, S_RESP} state_e;
  typedef enum logic [1:0] {M_INSERT, M_DELETE, M_RENAME} mode_e;

  localparam logic [END_W-1:0] SPAN = END_W'(1) << ADDR_BITS;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  state_e                 state_q;
  mode_e                  mode_q;
  req_e                   req_q;
  logic [KEY_BITS-1:0]    key_q, nkey_q;
  logic [LEN_BITS-1:0]    fsize_q, mem_bytes_q;
  logic [CNT_W-1:0]       count_q, step_q, g_q, f_q;
  logic [END_W-1:0]       prev_end_q, pos_q, maxgap_q, fit_start_q;
  logic                   fit_q, found_q, nfound_q;
  logic [ADDR_BITS-1:0]   found_start_q;
  logic [LEN_BITS-1:0]    found_len_q;
  logic [STATUS_BITS-1:0] res_status_q;
  logic [ADDR_BITS-1:0]   res_sa_q;
  logic [LEN_BITS-1:0]    res_len_q;
  logic                   rsp_valid_q;
  logic [STATUS_BITS-1:0] rsp_status_q;
  logic [ADDR_BITS-1:0]   rsp_sa_q;
  logic [LEN_BITS-1:0]    rsp_len_q;
  entry_t                 hold_q;

  entry_t                 chain [TABLE_ENTRIES+1];
  entry_t                 head, tail_in;
  logic                   shift_en;
  logic                   in_use, gap_valid;
  logic [END_W-1:0]       lim, hi, gap, head_end;
  logic [CNT_W-1:0]       gap_idx;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    fft_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_en),
      .entry_i (chain[k+1]),
      .entry_o (chain[k])
    );
  end

  assign head = chain[0];
  assign chain[TABLE_ENTRIES] = tail_in;

  assign lim = (END_W'(mem_bytes_q) > SPAN) ? SPAN : END_W'(mem_bytes_q);
  assign in_use = step_q < count_q;
  assign hi = (state_q == S_LAST) ? lim : END_W'(head.start);
  assign gap = (hi >= prev_end_q) ? hi - prev_end_q : '0;
  assign gap_valid = (state_q == S_LAST) || (state_q == S_SCAN && in_use);
  assign gap_idx = (state_q == S_LAST) ? count_q : step_q;
  assign head_end = END_W'(head.start) + END_W'(head.len);

  always_comb begin
    tail_in = head;
    shift_en = 1'b0;
    if (state_q == S_SCAN) begin
      shift_en = 1'b1;
      if (req_q == REQ_PACK && in_use) begin
        tail_in.start = pos_q[ADDR_BITS-1:0];
      end
    end else if (state_q == S_MOD) begin
      shift_en = 1'b1;
      unique case (mode_q)
        M_INSERT: begin
          if (step_q == g_q) begin
            tail_in.key = key_q;
            tail_in.start = fit_start_q[ADDR_BITS-1:0];
            tail_in.len = fsize_q;
          end else if (step_q > g_q) begin
            tail_in = hold_q;
          end
        end
        M_DELETE: begin
          if (step_q != '0 && step_q <= f_q) begin
            tail_in = hold_q;
          end
        end
        M_RENAME: begin
          if (step_q == f_q) begin
            tail_in.key = nkey_q;
          end
        end
        default: tail_in = head;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      hold_q <= head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_bytes_q <= LEN_BITS'(65536);
    end else if (cfg.valid) begin
      mem_bytes_q <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;
  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = rsp_valid_q;
  assign rsp.status = rsp_status_q;
  assign rsp.start_addr = rsp_sa_q;
  assign rsp.length = rsp_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= M_INSERT;
      count_q <= '0;
      step_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (state_q == S_RESP && (!rsp_valid_q || rsp.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            req_q <= req_e'(req.req_type);
            key_q <= req.file_key;
            nkey_q <= req.new_key;
            fsize_q <= req.file_size;
            step_q <= '0;
            prev_end_q <= '0;
            pos_q <= '0;
            maxgap_q <= '0;
            fit_q <= 1'b0;
            found_q <= 1'b0;
            nfound_q <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN, S_LAST: begin
          if (gap_valid) begin
            if (!fit_q && gap >= END_W'(fsize_q)) begin
              fit_q <= 1'b1;
              g_q <= gap_idx;
              fit_start_q <= prev_end_q;
            end
            if (gap > maxgap_q) begin
              maxgap_q <= gap;
            end
          end
          if (state_q == S_LAST) begin
            state_q <= S_DECIDE;
          end else begin
            if (in_use) begin
              prev_end_q <= head_end;
              pos_q <= pos_q + END_W'(head.len);
              if (head.key == key_q && !found_q) begin
                found_q <= 1'b1;
                f_q <= step_q;
                found_start_q <= head.start;
                found_len_q <= head.len;
              end
              if (head.key == nkey_q) begin
                nfound_q <= 1'b1;
              end
            end
            if (step_q == LAST_STEP) begin
              step_q <= '0;
              state_q <= S_LAST;
            end else begin
              step_q <= step_q + 1'b1;
            end
          end
        end
        S_DECIDE: begin
          res_status_q <= ST_OK;
          res_sa_q <= '0;
          res_len_q <= '0;
          state_q <= S_RESP;
          priority case (req_q)
            REQ_STORE: begin
              if (!fit_q) begin
                res_status_q <= ST_NO_SPACE;
              end else if (found_q) begin
                res_status_q <= ST_EXISTS;
              end else if (count_q == FULL) begin
                res_status_q <= ST_FULL;
              end else begin
                res_sa_q <= fit_start_q[ADDR_BITS-1:0];
                mode_q <= M_INSERT;
                count_q <= count_q + 1'b1;
                state_q <= S_MOD;
              end
            end
            REQ_LOOKUP: begin
              if (!found_q) begin
                res_status_q <= ST_NOT_FOUND;
              end else begin
                res_sa_q <= found_start_q;
                res_len_q <= found_len_q;
              end
            end
            REQ_ERASE: begin
              if (!found_q) begin
                res_status_q <= ST_NOT_FOUND;
              end else begin
                mode_q <= M_DELETE;
                count_q <= count_q - 1'b1;
                state_q <= S_MOD;
              end
            end
            REQ_RENAME: begin
              if (!found_q) begin
                res_status_q <= ST_NOT_FOUND;
              end else if (nfound_q) begin
                res_status_q <= ST_EXISTS;
              end else begin
                mode_q <= M_RENAME;
                state_q <= S_MOD;
              end
            end
            REQ_GAP: begin
              res_len_q <= maxgap_q[LEN_BITS-1:0];
            end
            default: begin
              res_status_q <= ST_OK;
            end
          endcase
        end
        S_MOD: begin
          if ((mode_q == M_DELETE && step_q == FULL) ||
              (mode_q != M_DELETE && step_q == LAST_STEP)) begin
            step_q <= '0;
            state_q <= S_RESP;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_RESP: begin
          if (!rsp_valid_q || rsp.ready) begin
            rsp_status_q <= res_status_q;
            rsp_sa_q <= res_sa_q;
            rsp_len_q <= res_len_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/fft_checker.sv
`default_nettype none
module fft_checker import fft_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   req_valid_i,
  input wire logic                   req_ready_i,
  input wire logic                   rsp_valid_i,
  input wire logic                   rsp_ready_i,
  input wire logic [STATUS_BITS-1:0] rsp_status_i,
  input wire logic [ADDR_BITS-1:0]   rsp_start_addr_i,
  input wire logic [LEN_BITS-1:0]    rsp_length_i
);
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i <= STATUS_BITS'(ST_FULL)))
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i != STATUS_BITS'(ST_OK)) |->
      (rsp_start_addr_i == '0 && rsp_length_i == '0))
    else $error("failed request returned nonzero fields");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_start_addr_i) &&
       $stable(rsp_length_i)))
    else $error("stalled response changed");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while busy");
endmodule

bind first_fit_extent_table fft_checker u_fft_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req.valid),
  .req_ready_i      (req.ready),
  .rsp_valid_i      (rsp.valid),
  .rsp_ready_i      (rsp.ready),
  .rsp_status_i     (rsp.status),
  .rsp_start_addr_i (rsp.start_addr),
  .rsp_length_i     (rsp.length)
);
`default_nettype wire
